FILE: hw/rtl/afpa_pkg.sv
// Shared types and constants for the animation frame position advance block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package afpa_pkg;

  // Fixed widths of the request and result fields.
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned PART_W  = 2;
  // Frame index plus one increment needs one extra bit during the walk.
  localparam int unsigned FRAME_W = FIELD_W + 1;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned PCOUNT_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_COUNT  = 2'd2;

  localparam logic [PCOUNT_W-1:0]   PART_COUNT_RST  = 3'd1;
  localparam logic [CFG_DATA_W-1:0] FRAME_COUNT_RST = 64'h0000_0000_0000_0001;
  localparam logic [CFG_DATA_W-1:0] LOOP_COUNT_RST  = 64'h0001_0001_0001_0001;

  // Configuration view of the part the sequencer is working on.
  typedef struct packed {
    logic [PART_W-1:0]  last;    // index of the last part in use
    logic [FIELD_W-1:0] frames;  // frame count of the selected part
    logic [FIELD_W-1:0] plays;   // play count of the selected part, never zero
  } part_info_t;

endpackage

`default_nettype wire

FILE: hw/rtl/afpa_if.sv
// Valid/ready channel interfaces for the request and result sides.
// Depends on afpa_pkg for the field widths.
`default_nettype none

interface afpa_in_if
  import afpa_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] frame_step;

  modport source (output valid, output frame_step, input ready);
  modport sink   (input valid, input frame_step, output ready);
endinterface

interface afpa_out_if
  import afpa_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [PART_W-1:0]  part_index;
  logic [FIELD_W-1:0] loop_index;
  logic [FIELD_W-1:0] frame_index;
  logic               empty_last_part;

  modport source (output valid, output part_index, output loop_index,
                  output frame_index, output empty_last_part, input ready);
  modport sink   (input valid, input part_index, input loop_index,
                  input frame_index, input empty_last_part, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/afpa_cfg_regs.sv
// Configuration registers and the per-part count selection.
// Depends on afpa_pkg.
`default_nettype none

module afpa_cfg_regs
  import afpa_pkg::*;
#(
  parameter int unsigned MAX_PARTS   = 4,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [PART_W-1:0]     part_i,
  output      part_info_t            info_o
);

  localparam logic [FIELD_W-1:0]  COUNT_MASK = FIELD_W'((17'd1 << COUNT_WIDTH) - 17'd1);
  localparam logic [PCOUNT_W-1:0] MAX_P      = PCOUNT_W'(MAX_PARTS);

  logic [PCOUNT_W-1:0]   part_count_q;
  logic [CFG_DATA_W-1:0] frame_counts_q;
  logic [CFG_DATA_W-1:0] loop_counts_q;
  logic [PCOUNT_W-1:0]   parts_used;
  logic [FIELD_W-1:0]    plays_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_count_q   <= PART_COUNT_RST;
      frame_counts_q <= FRAME_COUNT_RST;
      loop_counts_q  <= LOOP_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PART_COUNT:  part_count_q   <= cfg_data_i[PCOUNT_W-1:0];
        REG_FRAME_COUNT: frame_counts_q <= cfg_data_i;
        REG_LOOP_COUNT:  loop_counts_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A part count of zero means one part; anything above the maximum saturates.
  always_comb begin
    priority if (part_count_q == '0) begin
      parts_used = PCOUNT_W'(1);
    end else if (part_count_q > MAX_P) begin
      parts_used = MAX_P;
    end else begin
      parts_used = part_count_q;
    end
  end

  assign plays_raw = loop_counts_q[part_i*FIELD_W +: FIELD_W] & COUNT_MASK;

  assign info_o.last   = PART_W'(parts_used - PCOUNT_W'(1));
  assign info_o.frames = frame_counts_q[part_i*FIELD_W +: FIELD_W] & COUNT_MASK;
  // A play count of zero plays the part once.
  assign info_o.plays  = (plays_raw == '0) ? FIELD_W'(1) : plays_raw;

endmodule

`default_nettype wire

FILE: hw/rtl/afpa_sub_unit.sv
// Shared compare-and-subtract unit used by the part walk and the modulo steps.
// Depends on afpa_pkg.
`default_nettype none

module afpa_sub_unit
  import afpa_pkg::*;
(
  input  wire logic [FRAME_W-1:0] op_a_i,
  input  wire logic [FIELD_W-1:0] op_b_i,
  output      logic [FRAME_W-1:0] diff_o,
  output      logic               below_o
);

  logic [FRAME_W:0] full;

  // The extra top bit is the borrow: set when op_a is below op_b.
  assign full    = {1'b0, op_a_i} - {2'b00, op_b_i};
  assign diff_o  = full[FRAME_W-1:0];
  assign below_o = full[FRAME_W];

endmodule

`default_nettype wire

FILE: hw/rtl/afpa_walk.sv
// Sequencer for the position advance: part walk, last-part modulo, result register.
// Depends on afpa_pkg, the channel interfaces and afpa_sub_unit.
`default_nettype none

module afpa_walk
  import afpa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  afpa_in_if.sink          in_chan,
  afpa_out_if.source       out_chan,
  input  wire part_info_t  info_i,
  output      logic [PART_W-1:0] part_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int unsigned CNT_W = $clog2(FRAME_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_W - 1);

  logic [1:0]         state_q, state_d;
  logic [PART_W-1:0]  part_q, part_d;
  logic [FIELD_W-1:0] loop_q, loop_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [FIELD_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               empty_q, empty_d;

  logic               out_valid_q, out_valid_d;
  logic [PART_W-1:0]  out_part_q;
  logic [FIELD_W-1:0] out_loop_q;
  logic [FIELD_W-1:0] out_frame_q;
  logic               out_empty_q;
  logic               out_load;

  logic [FRAME_W-1:0] op_a;
  logic [FRAME_W-1:0] diff;
  logic               below;
  logic [FIELD_W:0]   loop_inc;
  logic               loop_wrap;
  logic               accept;

  // In the modulo steps the unit sees the partial remainder with the next
  // dividend bit shifted in; otherwise it sees the running frame index.
  assign op_a = (state_q == ST_MOD) ? {rem_q, frame_q[FRAME_W-1]} : frame_q;

  afpa_sub_unit u_sub (
    .op_a_i  (op_a),
    .op_b_i  (info_i.frames),
    .diff_o  (diff),
    .below_o (below)
  );

  assign loop_inc  = {1'b0, loop_q} + {{FIELD_W{1'b0}}, 1'b1};
  assign loop_wrap = loop_inc >= {1'b0, info_i.plays};
  assign accept    = in_chan.valid && in_chan.ready;

  assign in_chan.ready = (state_q == ST_IDLE);
  assign part_o        = part_q;

  always_comb begin
    state_d  = state_q;
    part_d   = part_q;
    loop_d   = loop_q;
    frame_d  = frame_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    empty_d  = empty_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          frame_d = {1'b0, frame_q[FIELD_W-1:0]} + {1'b0, in_chan.frame_step};
          part_d  = (part_q > info_i.last) ? info_i.last : part_q;
          empty_d = 1'b0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (below) begin
          state_d = ST_DONE;
        end else if (part_q == info_i.last) begin
          if (info_i.frames == '0) begin
            frame_d = '0;
            empty_d = 1'b1;
            state_d = ST_DONE;
          end else begin
            rem_d   = '0;
            cnt_d   = '0;
            state_d = ST_MOD;
          end
        end else if (info_i.frames == '0) begin
          // An empty inner part consumes no frames, so it is left at once.
          loop_d = '0;
          part_d = part_q + PART_W'(1);
        end else begin
          frame_d = diff;
          if (loop_wrap) begin
            loop_d = '0;
            part_d = part_q + PART_W'(1);
          end else begin
            loop_d = loop_inc[FIELD_W-1:0];
          end
        end
      end
      ST_MOD: begin
        // One restoring step per cycle, most significant dividend bit first.
        rem_d   = below ? op_a[FIELD_W-1:0] : diff[FIELD_W-1:0];
        frame_d = {frame_q[FRAME_W-2:0], 1'b0};
        cnt_d   = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          frame_d = {1'b0, rem_d};
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_chan.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      part_q      <= '0;
      loop_q      <= '0;
      frame_q     <= '0;
      empty_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      part_q      <= part_d;
      loop_q      <= loop_d;
      frame_q     <= frame_d;
      empty_q     <= empty_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (out_load) begin
      out_part_q  <= part_q;
      out_loop_q  <= loop_q;
      out_frame_q <= frame_q[FIELD_W-1:0];
      out_empty_q <= empty_q;
    end
  end

  assign out_chan.valid           = out_valid_q;
  assign out_chan.part_index      = out_part_q;
  assign out_chan.loop_index      = out_loop_q;
  assign out_chan.frame_index     = out_frame_q;
  assign out_chan.empty_last_part = out_empty_q;

endmodule

`default_nettype wire

FILE: hw/rtl/animation_frame_position_advance.sv
// Top level of the animation frame position advance block.
// Depends on afpa_pkg, the channel interfaces, afpa_cfg_regs and afpa_walk.
//
// The block keeps a playback position (part, loop within the part, frame
// within the part). Each request on in_chan carries a frame step; the block
// adds it to the frame index, walks forward through the configured parts and
// returns the new position as one result on out_chan.
//
// Sequence: the request is taken while idle; the walk then makes one pass per
// play of each non-last part that has frames (an empty inner part is left at
// once), stops in the part where the frame index falls below the frame count,
// and, when the frame must be wrapped by modulo of the last part's frame count,
// runs a restoring division; then the result register is loaded. The shared
// compare-subtract unit does one pass or one remainder bit per cycle. The block
// takes one request at a time; in_chan.ready is high only while it is idle.
//
// The result register lets a new request be taken while a result still waits.
// If the receiver stalls, a finished advance holds until the register frees.
// Reset sets the position to zero and the registers to one part of one frame
// played once. Configuration writes are taken at any edge with cfg_we_i high
// and must only happen while the block is idle; unknown indexes are ignored.
`default_nettype none

module animation_frame_position_advance
  import afpa_pkg::*;
#(
  parameter int unsigned MAX_PARTS   = 4,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  afpa_in_if.sink                    in_chan,
  afpa_out_if.source                 out_chan,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  part_info_t        info;
  logic [PART_W-1:0] sel_part;

  // Register file; it also decodes the counts of the part being walked.
  afpa_cfg_regs #(
    .MAX_PARTS   (MAX_PARTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .part_i     (sel_part),
    .info_o     (info)
  );

  // Sequencer with the position state, the shared unit and the result register.
  afpa_walk u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .info_i   (info),
    .part_o   (sel_part)
  );

endmodule

`default_nettype wire
